FILE: hdl/ec_point_scalar_multiply_core_macros.svh
// Shared assertion macros
`ifndef EC_POINT_SCALAR_MULTIPLY_CORE_MACROS_SVH
`define EC_POINT_SCALAR_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication
`define ECPSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecpsm assertion failed");

// next-cycle implication
`define ECPSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecpsm assertion failed");

`endif

FILE: hdl/ecpsm_pkg.sv
package ecpsm_pkg;

  localparam int DEFAULT_OPERAND_BITS = 256;

  typedef logic [2:0]  action_t;
  typedef logic [1:0]  word_idx_t;
  typedef logic [63:0] word_t;
  typedef logic [8:0]  scalar_len_t;
  typedef logic [1:0]  coord_t;

  localparam action_t ACT_MODULUS = 3'd0;
  localparam action_t ACT_COEF_A  = 3'd1;
  localparam action_t ACT_BASE_X  = 3'd2;
  localparam action_t ACT_BASE_Y  = 3'd3;
  localparam action_t ACT_BASE_Z  = 3'd4;
  localparam action_t ACT_SCALAR  = 3'd5;
  localparam action_t ACT_START   = 3'd6;

  localparam coord_t COORD_X = 2'd0;
  localparam coord_t COORD_Y = 2'd1;
  localparam coord_t COORD_Z = 2'd2;

  // operand memory map
  typedef logic [4:0] ent_t;
  localparam int NUM_ENT = 22;
  localparam ent_t E_M  = 5'd0;
  localparam ent_t E_A  = 5'd1;
  localparam ent_t E_X  = 5'd2;
  localparam ent_t E_Y  = 5'd3;
  localparam ent_t E_Z  = 5'd4;
  localparam ent_t E_K  = 5'd5;
  localparam ent_t E_AR = 5'd6;
  localparam ent_t E_BX = 5'd7;
  localparam ent_t E_BY = 5'd8;
  localparam ent_t E_BZ = 5'd9;
  localparam ent_t E_PX = 5'd10;
  localparam ent_t E_PY = 5'd11;
  localparam ent_t E_PZ = 5'd12;
  // doubling temporaries
  localparam ent_t D_W  = 5'd13;
  localparam ent_t D_S  = 5'd14;
  localparam ent_t D_B  = 5'd15;
  localparam ent_t D_H  = 5'd16;
  localparam ent_t D_T  = 5'd17;
  localparam ent_t D_X3 = 5'd18;
  localparam ent_t D_Y3 = 5'd19;
  localparam ent_t D_Z3 = 5'd20;
  // addition temporaries
  localparam ent_t A_U1 = 5'd13;
  localparam ent_t A_U2 = 5'd14;
  localparam ent_t A_V1 = 5'd15;
  localparam ent_t A_V2 = 5'd16;
  localparam ent_t A_U  = 5'd17;
  localparam ent_t A_V  = 5'd18;
  localparam ent_t A_W  = 5'd19;
  localparam ent_t A_AA = 5'd20;
  localparam ent_t A_T  = 5'd21;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_RED = 3'd1,
    OP_SCL = 3'd2,
    OP_ADD = 3'd3,
    OP_SUB = 3'd4,
    OP_CPY = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    ent_t       dst;
    ent_t       s1;
    ent_t       s2;
    logic [3:0] k;
  } uop_t;

  typedef logic [6:0] pc_t;
  localparam pc_t PC_INIT     = 7'd0;
  localparam pc_t PC_INIT_END = 7'd6;
  localparam pc_t PC_ZERO     = 7'd7;
  localparam pc_t PC_ZERO_END = 7'd9;
  localparam pc_t PC_DBL      = 7'd10;
  localparam pc_t PC_DBL_END  = 7'd36;
  localparam pc_t PC_ADD      = 7'd37;
  localparam pc_t PC_ADD_END  = 7'd64;

  function automatic uop_t mk(input op_t op, input ent_t d, input ent_t a, input ent_t b,
                              input logic [3:0] k);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.s1  = a;
    u.s2  = b;
    u.k   = k;
    return u;
  endfunction

  function automatic uop_t uop_rom(input pc_t pc);
    uop_t u;
    unique case (pc)
      // start: reduce base point and a, seed accumulator
      7'd0:  u = mk(OP_RED, E_BX, E_X, E_X, 4'd0);
      7'd1:  u = mk(OP_RED, E_BY, E_Y, E_Y, 4'd0);
      7'd2:  u = mk(OP_RED, E_BZ, E_Z, E_Z, 4'd0);
      7'd3:  u = mk(OP_RED, E_AR, E_A, E_A, 4'd0);
      7'd4:  u = mk(OP_CPY, E_PX, E_BX, E_BX, 4'd0);
      7'd5:  u = mk(OP_CPY, E_PY, E_BY, E_BY, 4'd0);
      7'd6:  u = mk(OP_CPY, E_PZ, E_BZ, E_BZ, 4'd0);
      // zero modulus: clear accumulator
      7'd7:  u = mk(OP_SCL, E_PX, E_M, E_M, 4'd0);
      7'd8:  u = mk(OP_SCL, E_PY, E_M, E_M, 4'd0);
      7'd9:  u = mk(OP_SCL, E_PZ, E_M, E_M, 4'd0);
      // point doubling
      7'd10: u = mk(OP_MUL, D_W,  E_AR, E_PZ, 4'd0);
      7'd11: u = mk(OP_MUL, D_W,  D_W,  E_PZ, 4'd0);
      7'd12: u = mk(OP_MUL, D_T,  E_PX, E_PX, 4'd0);
      7'd13: u = mk(OP_SCL, D_T,  D_T,  D_T,  4'd3);
      7'd14: u = mk(OP_ADD, D_W,  D_W,  D_T,  4'd0);
      7'd15: u = mk(OP_MUL, D_S,  E_PY, E_PZ, 4'd0);
      7'd16: u = mk(OP_MUL, D_B,  E_PX, E_PY, 4'd0);
      7'd17: u = mk(OP_MUL, D_B,  D_B,  D_S,  4'd0);
      7'd18: u = mk(OP_MUL, D_H,  D_W,  D_W,  4'd0);
      7'd19: u = mk(OP_SCL, D_T,  D_B,  D_B,  4'd8);
      7'd20: u = mk(OP_SUB, D_H,  D_H,  D_T,  4'd0);
      7'd21: u = mk(OP_MUL, D_X3, D_H,  D_S,  4'd0);
      7'd22: u = mk(OP_SCL, D_X3, D_X3, D_X3, 4'd2);
      7'd23: u = mk(OP_SCL, D_Y3, D_B,  D_B,  4'd4);
      7'd24: u = mk(OP_SUB, D_Y3, D_Y3, D_H,  4'd0);
      7'd25: u = mk(OP_MUL, D_Y3, D_Y3, D_W,  4'd0);
      7'd26: u = mk(OP_MUL, D_T,  E_PY, E_PY, 4'd0);
      7'd27: u = mk(OP_MUL, D_T,  D_T,  D_S,  4'd0);
      7'd28: u = mk(OP_MUL, D_T,  D_T,  D_S,  4'd0);
      7'd29: u = mk(OP_SCL, D_T,  D_T,  D_T,  4'd8);
      7'd30: u = mk(OP_SUB, D_Y3, D_Y3, D_T,  4'd0);
      7'd31: u = mk(OP_MUL, D_Z3, D_S,  D_S,  4'd0);
      7'd32: u = mk(OP_MUL, D_Z3, D_Z3, D_S,  4'd0);
      7'd33: u = mk(OP_SCL, D_Z3, D_Z3, D_Z3, 4'd8);
      7'd34: u = mk(OP_CPY, E_PX, D_X3, D_X3, 4'd0);
      7'd35: u = mk(OP_CPY, E_PY, D_Y3, D_Y3, 4'd0);
      7'd36: u = mk(OP_CPY, E_PZ, D_Z3, D_Z3, 4'd0);
      // point addition of the base point
      7'd37: u = mk(OP_MUL, A_U1, E_BY, E_PZ, 4'd0);
      7'd38: u = mk(OP_MUL, A_U2, E_PY, E_BZ, 4'd0);
      7'd39: u = mk(OP_MUL, A_V1, E_BX, E_PZ, 4'd0);
      7'd40: u = mk(OP_MUL, A_V2, E_PX, E_BZ, 4'd0);
      7'd41: u = mk(OP_SUB, A_U,  A_U1, A_U2, 4'd0);
      7'd42: u = mk(OP_SUB, A_V,  A_V1, A_V2, 4'd0);
      7'd43: u = mk(OP_MUL, A_W,  E_PZ, E_BZ, 4'd0);
      7'd44: u = mk(OP_MUL, A_AA, A_U,  A_U,  4'd0);
      7'd45: u = mk(OP_MUL, A_AA, A_AA, A_W,  4'd0);
      7'd46: u = mk(OP_MUL, A_T,  A_V,  A_V,  4'd0);
      7'd47: u = mk(OP_MUL, A_T,  A_T,  A_V,  4'd0);
      7'd48: u = mk(OP_SUB, A_AA, A_AA, A_T,  4'd0);
      7'd49: u = mk(OP_MUL, A_T,  A_V,  A_V,  4'd0);
      7'd50: u = mk(OP_MUL, A_T,  A_T,  A_V2, 4'd0);
      7'd51: u = mk(OP_SCL, A_T,  A_T,  A_T,  4'd2);
      7'd52: u = mk(OP_SUB, A_AA, A_AA, A_T,  4'd0);
      7'd53: u = mk(OP_MUL, E_PX, A_V,  A_AA, 4'd0);
      7'd54: u = mk(OP_MUL, A_T,  A_V,  A_V,  4'd0);
      7'd55: u = mk(OP_MUL, A_T,  A_T,  A_V2, 4'd0);
      7'd56: u = mk(OP_SUB, A_T,  A_T,  A_AA, 4'd0);
      7'd57: u = mk(OP_MUL, E_PY, A_T,  A_U,  4'd0);
      7'd58: u = mk(OP_MUL, A_T,  A_V,  A_V,  4'd0);
      7'd59: u = mk(OP_MUL, A_T,  A_T,  A_V,  4'd0);
      7'd60: u = mk(OP_MUL, A_T,  A_T,  A_U2, 4'd0);
      7'd61: u = mk(OP_SUB, E_PY, E_PY, A_T,  4'd0);
      7'd62: u = mk(OP_MUL, E_PZ, A_V,  A_V,  4'd0);
      7'd63: u = mk(OP_MUL, E_PZ, E_PZ, A_V,  4'd0);
      7'd64: u = mk(OP_MUL, E_PZ, E_PZ, A_W,  4'd0);
      default: u = mk(OP_CPY, E_M, E_M, E_M, 4'd0);
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/ecpsm_in_if.sv
interface ecpsm_in_if;
  import ecpsm_pkg::*;
  logic        valid;
  logic        ready;
  action_t     action;
  word_idx_t   word_index;
  word_t       word_value;
  scalar_len_t scalar_length;

  modport source (output valid, action, word_index, word_value, scalar_length, input ready);
  modport sink   (input valid, action, word_index, word_value, scalar_length, output ready);
endinterface

FILE: hdl/ecpsm_out_if.sv
interface ecpsm_out_if;
  import ecpsm_pkg::*;
  logic      valid;
  logic      ready;
  coord_t    result_coordinate;
  word_idx_t result_word_index;
  word_t     result_word;
  logic      last_word;

  modport source (output valid, result_coordinate, result_word_index, result_word, last_word,
                  input ready);
  modport sink   (input valid, result_coordinate, result_word_index, result_word, last_word,
                  output ready);
endinterface

FILE: hdl/ec_point_scalar_multiply_core.sv
// A load item is accepted only in S_IDLE, then merged into memory by a read-modify-write.
// Start (nonzero modulus): 4 reductions, then per scalar bit 27 doubling micro-ops and,
// for a one bit, 28 addition micro-ops; a zero modulus only clears the accumulator. A
// multiply is a bit-serial loop of full-width modular additions, which sets the rate.
// Results: 3*WORDS words, one per cycle while ready is high; S_ORD reads each coordinate.
// Synchronous active-low reset returns the sequencer to idle; operand memory is not cleared.
module ec_point_scalar_multiply_core #(
  parameter int OPERAND_BITS = ecpsm_pkg::DEFAULT_OPERAND_BITS
) (
  input logic         clk,
  input logic         rst_n,
  ecpsm_in_if.sink    in_chan,
  ecpsm_out_if.source out_chan
);
  import ecpsm_pkg::*;
  `include "ec_point_scalar_multiply_core_macros.svh"

  localparam int WORDS    = (OPERAND_BITS + 63) / 64;
  localparam int NBITS    = WORDS * 64;
  localparam int IDXW     = $clog2(NBITS);
  localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TOP_BITS = OPERAND_BITS - (WORDS - 1) * 64;
  localparam logic [63:0] TOP_MASK = {64{1'b1}} >> (64 - TOP_BITS);

  typedef logic [NBITS-1:0] num_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LD   = 11'b00000000010,
    S_SM   = 11'b00000000100,
    S_SK   = 11'b00000001000,
    S_R1   = 11'b00000010000,
    S_R2   = 11'b00000100000,
    S_R3   = 11'b00001000000,
    S_EX   = 11'b00010000000,
    S_WR   = 11'b00100000000,
    S_ORD  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  num_t mem [NUM_ENT];
  num_t rdata_r;
  ent_t rd_addr;
  logic we;
  ent_t wa;
  num_t wd;

  state_t      state_r, state_nxt;
  pc_t         pc_r, pc_nxt;
  scalar_len_t bitpos_r, bitpos_nxt;
  num_t        m_r, m_nxt, k_r, k_nxt, a_r, a_nxt, b_r, b_nxt, r_r, r_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt;
  logic [3:0]  kc_r, kc_nxt;
  ent_t        ld_ent_r, ld_ent_nxt;
  word_idx_t   ld_word_r, ld_word_nxt;
  word_t       ld_val_r, ld_val_nxt;
  scalar_len_t len_r, len_nxt;
  coord_t      c_r, c_nxt;
  logic [WW-1:0] w_r, w_nxt;

  uop_t uop;
  logic kbit;
  logic in_fire, out_fire;

  function automatic num_t madd(input num_t p, input num_t q, input logic ci, input num_t m);
    logic [NBITS:0] t;
    logic [NBITS:0] d;
    t = {1'b0, p} + {1'b0, q} + {{NBITS{1'b0}}, ci};
    d = t - {1'b0, m};
    return (t >= {1'b0, m}) ? d[NBITS-1:0] : t[NBITS-1:0];
  endfunction

  function automatic num_t msub(input num_t p, input num_t q, input num_t m);
    logic [NBITS:0] t;
    t = {1'b0, p} - {1'b0, q};
    return t[NBITS] ? (t[NBITS-1:0] + m) : t[NBITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign uop      = uop_rom(pc_r);
  assign kbit     = (32'(bitpos_r) < NBITS) && k_r[bitpos_r[IDXW-1:0]];
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  assign in_chan.ready              = (state_r == S_IDLE);
  assign out_chan.valid             = (state_r == S_OUT);
  assign out_chan.result_coordinate = c_r;
  assign out_chan.result_word_index = 2'(w_r);
  assign out_chan.result_word       = rdata_r[64*int'(w_r) +: 64];
  assign out_chan.last_word         = (c_r == COORD_Z) && (w_r == WW'(WORDS - 1));

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    bitpos_nxt  = bitpos_r;
    m_nxt       = m_r;
    k_nxt       = k_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    r_nxt       = r_r;
    cnt_nxt     = cnt_r;
    ph_nxt      = ph_r;
    kc_nxt      = kc_r;
    ld_ent_nxt  = ld_ent_r;
    ld_word_nxt = ld_word_r;
    ld_val_nxt  = ld_val_r;
    len_nxt     = len_r;
    c_nxt       = c_r;
    w_nxt       = w_r;
    rd_addr     = uop.s1;
    we          = 1'b0;
    wa          = uop.dst;
    wd          = r_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.action <= ACT_SCALAR) begin
            if (int'(in_chan.word_index) < WORDS) begin
              rd_addr     = ent_t'(in_chan.action);
              ld_ent_nxt  = ent_t'(in_chan.action);
              ld_word_nxt = in_chan.word_index;
              ld_val_nxt  = (int'(in_chan.word_index) == WORDS - 1) ?
                            (in_chan.word_value & TOP_MASK) : in_chan.word_value;
              state_nxt   = S_LD;
            end
          end else if (in_chan.action == ACT_START) begin
            rd_addr   = E_M;
            len_nxt   = in_chan.scalar_length;
            state_nxt = S_SM;
          end
        end
      end
      S_LD: begin
        we = 1'b1;
        wa = ld_ent_r;
        wd = rdata_r;
        wd[64*int'(ld_word_r) +: 64] = ld_val_r;
        state_nxt = S_IDLE;
      end
      S_SM: begin
        m_nxt     = rdata_r;
        rd_addr   = E_K;
        state_nxt = S_SK;
      end
      S_SK: begin
        k_nxt = rdata_r;
        if (m_r == '0) begin
          pc_nxt = PC_ZERO;
        end else begin
          pc_nxt     = PC_INIT;
          bitpos_nxt = (len_r > 9'd1) ? (len_r - 9'd1) : 9'd0;
        end
        state_nxt = S_R1;
      end
      S_R1: begin
        rd_addr   = uop.s1;
        state_nxt = S_R2;
      end
      S_R2: begin
        a_nxt     = rdata_r;
        rd_addr   = uop.s2;
        state_nxt = S_R3;
      end
      S_R3: begin
        b_nxt     = rdata_r;
        r_nxt     = '0;
        cnt_nxt   = IDXW'(NBITS - 1);
        ph_nxt    = 1'b0;
        kc_nxt    = uop.k;
        state_nxt = S_EX;
      end
      S_EX: begin
        unique case (uop.op)
          OP_MUL: begin
            if (!ph_r) begin
              r_nxt = madd(r_r, r_r, 1'b0, m_r);
              if (b_r[cnt_r]) begin
                ph_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                state_nxt = S_WR;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end else begin
              r_nxt  = madd(r_r, a_r, 1'b0, m_r);
              ph_nxt = 1'b0;
              if (cnt_r == '0) begin
                state_nxt = S_WR;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          OP_RED: begin
            r_nxt = madd(r_r, r_r, a_r[cnt_r], m_r);
            if (cnt_r == '0) begin
              state_nxt = S_WR;
            end else begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_SCL: begin
            if (kc_r == '0) begin
              state_nxt = S_WR;
            end else begin
              r_nxt  = madd(r_r, a_r, 1'b0, m_r);
              kc_nxt = kc_r - 4'd1;
            end
          end
          OP_ADD: begin
            r_nxt     = madd(a_r, b_r, 1'b0, m_r);
            state_nxt = S_WR;
          end
          OP_SUB: begin
            r_nxt     = msub(a_r, b_r, m_r);
            state_nxt = S_WR;
          end
          OP_CPY: begin
            r_nxt     = a_r;
            state_nxt = S_WR;
          end
          default: state_nxt = S_WR;
        endcase
      end
      S_WR: begin
        we = 1'b1;
        wa = uop.dst;
        wd = r_r;
        priority if (pc_r == PC_ZERO_END) begin
          c_nxt     = COORD_X;
          w_nxt     = '0;
          state_nxt = S_ORD;
        end else if (pc_r == PC_DBL_END && kbit) begin
          pc_nxt    = PC_ADD;
          state_nxt = S_R1;
        end else if (pc_r == PC_INIT_END || pc_r == PC_DBL_END || pc_r == PC_ADD_END) begin
          if (bitpos_r != '0) begin
            bitpos_nxt = bitpos_r - 9'd1;
            pc_nxt     = PC_DBL;
            state_nxt  = S_R1;
          end else begin
            c_nxt     = COORD_X;
            w_nxt     = '0;
            state_nxt = S_ORD;
          end
        end else begin
          pc_nxt    = pc_r + 7'd1;
          state_nxt = S_R1;
        end
      end
      S_ORD: begin
        rd_addr   = E_PX + ent_t'(c_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        rd_addr = E_PX + ent_t'(c_r);
        if (out_fire) begin
          if (w_r == WW'(WORDS - 1)) begin
            w_nxt = '0;
            if (c_r == COORD_Z) begin
              state_nxt = S_IDLE;
            end else begin
              c_nxt     = c_r + 2'd1;
              state_nxt = S_ORD;
            end
          end else begin
            w_nxt = w_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bitpos_r <= '0;
    end else begin
      state_r  <= state_nxt;
      bitpos_r <= bitpos_nxt;
    end
    pc_r      <= pc_nxt;
    m_r       <= m_nxt;
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    r_r       <= r_nxt;
    cnt_r     <= cnt_nxt;
    ph_r      <= ph_nxt;
    kc_r      <= kc_nxt;
    ld_ent_r  <= ld_ent_nxt;
    ld_word_r <= ld_word_nxt;
    ld_val_r  <= ld_val_nxt;
    len_r     <= len_nxt;
    c_r       <= c_nxt;
    w_r       <= w_nxt;
  end

  `ECPSM_ASSERT_NOW(a_no_overlap, out_chan.valid, !in_chan.ready)
  `ECPSM_ASSERT_NOW(a_write_state, we, (state_r == S_LD) || (state_r == S_WR))
  `ECPSM_ASSERT_NEXT(a_last_to_idle, out_fire && out_chan.last_word, in_chan.ready)
  `ECPSM_ASSERT_NOW(a_last_is_z, out_chan.valid && out_chan.last_word,
                    out_chan.result_coordinate == COORD_Z)

endmodule

FILE: verif/ecpsm_checker.sv
module ecpsm_checker (
  input  logic  clk,
  input  logic  rst_n,
  ecpsm_in_if   in_mon,
  ecpsm_out_if  out_mon,
  output int    errors,
  output int    pending
);
  import ecpsm_pkg::*;

  typedef bit [255:0] big_t;

  typedef struct {
    coord_t    coord;
    word_idx_t widx;
    word_t     word;
    logic      last;
  } res_word_t;

  res_word_t res_q[$];

  big_t mod_r, coef_r, scal_r;
  big_t base_pt[3];
  big_t acc_pt[3];
  big_t base_red[3];
  big_t coef_red;

  function automatic big_t madd(big_t x, big_t y, big_t m);
    bit [256:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[255:0];
  endfunction

  function automatic big_t msub(big_t x, big_t y, big_t m);
    if (x >= y) return x - y;
    return x - y + m;
  endfunction

  function automatic big_t mred(big_t x, big_t m);
    bit [256:0] r;
    r = '0;
    for (int i = 255; i >= 0; i--) begin
      r = {r[255:0], x[i]};
      if (r >= {1'b0, m}) r = r - {1'b0, m};
    end
    return r[255:0];
  endfunction

  function automatic big_t mmul(big_t x, big_t y, big_t m);
    big_t r;
    r = '0;
    for (int i = 255; i >= 0; i--) begin
      r = madd(r, r, m);
      if (y[i]) r = madd(r, x, m);
    end
    return r;
  endfunction

  function automatic big_t mscl(big_t x, int k, big_t m);
    big_t r;
    r = '0;
    for (int i = 0; i < k; i++) r = madd(r, x, m);
    return r;
  endfunction

  task automatic pt_double();
    big_t w, s, b, h, t, x3, y3, z3, m;
    m  = mod_r;
    w  = mmul(coef_red, acc_pt[2], m);
    w  = mmul(w, acc_pt[2], m);
    t  = mmul(acc_pt[0], acc_pt[0], m);
    t  = mscl(t, 3, m);
    w  = madd(w, t, m);
    s  = mmul(acc_pt[1], acc_pt[2], m);
    b  = mmul(acc_pt[0], acc_pt[1], m);
    b  = mmul(b, s, m);
    h  = mmul(w, w, m);
    t  = mscl(b, 8, m);
    h  = msub(h, t, m);
    x3 = mmul(h, s, m);
    x3 = mscl(x3, 2, m);
    y3 = mscl(b, 4, m);
    y3 = msub(y3, h, m);
    y3 = mmul(y3, w, m);
    t  = mmul(acc_pt[1], acc_pt[1], m);
    t  = mmul(t, s, m);
    t  = mmul(t, s, m);
    t  = mscl(t, 8, m);
    y3 = msub(y3, t, m);
    z3 = mmul(s, s, m);
    z3 = mmul(z3, s, m);
    z3 = mscl(z3, 8, m);
    acc_pt[0] = x3;
    acc_pt[1] = y3;
    acc_pt[2] = z3;
  endtask

  task automatic pt_add_base();
    big_t u1, u2, v1, v2, u, v, w, aa, t, m;
    m  = mod_r;
    u1 = mmul(base_red[1], acc_pt[2], m);
    u2 = mmul(acc_pt[1], base_red[2], m);
    v1 = mmul(base_red[0], acc_pt[2], m);
    v2 = mmul(acc_pt[0], base_red[2], m);
    u  = msub(u1, u2, m);
    v  = msub(v1, v2, m);
    w  = mmul(acc_pt[2], base_red[2], m);
    aa = mmul(u, u, m);
    aa = mmul(aa, w, m);
    t  = mmul(v, v, m);
    t  = mmul(t, v, m);
    aa = msub(aa, t, m);
    t  = mmul(v, v, m);
    t  = mmul(t, v2, m);
    t  = mscl(t, 2, m);
    aa = msub(aa, t, m);
    acc_pt[0] = mmul(v, aa, m);
    t  = mmul(v, v, m);
    t  = mmul(t, v2, m);
    t  = msub(t, aa, m);
    acc_pt[1] = mmul(t, u, m);
    t  = mmul(v, v, m);
    t  = mmul(t, v, m);
    t  = mmul(t, u2, m);
    acc_pt[1] = msub(acc_pt[1], t, m);
    acc_pt[2] = mmul(v, v, m);
    acc_pt[2] = mmul(acc_pt[2], v, m);
    acc_pt[2] = mmul(acc_pt[2], w, m);
  endtask

  task automatic scalar_mult(scalar_len_t len);
    int pos;
    res_word_t r;
    if (mod_r == '0) begin
      for (int c = 0; c < 3; c++) acc_pt[c] = '0;
    end else begin
      for (int c = 0; c < 3; c++) base_red[c] = mred(base_pt[c], mod_r);
      coef_red = mred(coef_r, mod_r);
      for (int c = 0; c < 3; c++) acc_pt[c] = base_red[c];
      pos = (len > 1) ? int'(len) - 1 : 0;
      while (pos > 0) begin
        pos--;
        pt_double();
        if (pos < 256 && scal_r[pos]) pt_add_base();
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int w = 0; w < 4; w++) begin
        r.coord = coord_t'(c);
        r.widx  = word_idx_t'(w);
        r.word  = acc_pt[c][w*64 +: 64];
        r.last  = (c == 2 && w == 3);
        res_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    res_word_t e;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (res_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = res_q.pop_front();
          if (out_mon.result_coordinate !== e.coord) begin
            $error("result_coordinate: expected %0d actual %0d", e.coord,
                   out_mon.result_coordinate);
            errors++;
          end
          if (out_mon.result_word_index !== e.widx) begin
            $error("result_word_index: expected %0d actual %0d", e.widx,
                   out_mon.result_word_index);
            errors++;
          end
          if (out_mon.result_word !== e.word) begin
            $error("result_word: expected %h actual %h", e.word, out_mon.result_word);
            errors++;
          end
          if (out_mon.last_word !== e.last) begin
            $error("last_word: expected %b actual %b", e.last, out_mon.last_word);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_MODULUS: mod_r[in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_COEF_A:  coef_r[in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_BASE_X:  base_pt[0][in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_BASE_Y:  base_pt[1][in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_BASE_Z:  base_pt[2][in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_SCALAR:  scal_r[in_mon.word_index*64 +: 64] = in_mon.word_value;
          ACT_START:   scalar_mult(in_mon.scalar_length);
          default: ;
        endcase
      end
      pending = res_q.size();
    end
  end
endmodule

FILE: verif/tb_top.sv
module tb_top;
  import ecpsm_pkg::*;

  localparam action_t ACT_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 80_000_000;

  typedef bit [255:0] big_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   cycles;
  int   sent;
  bit   held_once;

  ecpsm_in_if  in_if ();
  ecpsm_out_if out_if ();

  ec_point_scalar_multiply_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  ecpsm_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_if),
    .out_mon (out_if),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic big_t rand_big();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // sink side: one long hold-off on the first result, then random stalls
  initial begin
    out_if.ready = 1'b0;
    held_once = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_once && out_if.valid) begin
        held_once = 1;
        out_if.ready = 1'b0;
        repeat (3000) @(negedge clk);
      end
      out_if.ready = (pick_gap() == 0);
    end
  end

  task automatic send_item(action_t act, word_idx_t idx, word_t val, scalar_len_t len);
    int gap;
    @(negedge clk);
    in_if.valid         = 1'b1;
    in_if.action        = act;
    in_if.word_index    = idx;
    in_if.word_value    = val;
    in_if.scalar_length = len;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic load_operand(action_t act, big_t v);
    for (int w = 0; w < 4; w++)
      send_item(act, word_idx_t'(w), v[w*64 +: 64], scalar_len_t'($urandom));
  endtask

  task automatic start_run(scalar_len_t len);
    send_item(ACT_START, word_idx_t'($urandom), word_t'({$urandom, $urandom}), len);
  endtask

  initial begin
    big_t v;
    int   pick;
    int   seqs;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.action        = ACT_MODULUS;
    in_if.word_index    = '0;
    in_if.word_value    = '0;
    in_if.scalar_length = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes: all-ones modulus, X equal to it, Z = 1
    load_operand(ACT_MODULUS, '1);
    load_operand(ACT_COEF_A, rand_big());
    load_operand(ACT_BASE_X, '1);
    load_operand(ACT_BASE_Y, rand_big());
    load_operand(ACT_BASE_Z, big_t'(1));
    load_operand(ACT_SCALAR, rand_big());
    start_run(9'd0);
    start_run(9'd1);
    start_run(9'd2);
    send_item(ACT_UNUSED, 2'd3, '1, 9'h1ff);
    start_run(9'd3);
    // zero modulus clears the result
    load_operand(ACT_MODULUS, '0);
    start_run(9'd5);
    // one-word modulus, zero scalar, length past the operand width
    send_item(ACT_MODULUS, 2'd0, 64'hffff_ffff_ffff_ffc5, 9'd0);
    load_operand(ACT_SCALAR, '0);
    start_run(9'd257);

    seqs = 0;
    while (sent < 100) begin
      seqs++;
      if (seqs == 4) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        load_operand(ACT_MODULUS, '0);
      end else if (pick < 35) begin
        v = rand_big();
        v[255] = 1'b1;
        v[0]   = 1'b1;
        load_operand(ACT_MODULUS, v);
      end else if (pick < 50) begin
        load_operand(ACT_MODULUS, big_t'({$urandom, $urandom} | 64'd1));
      end
      for (int op = 1; op <= 5; op++)
        for (int w = 0; w < 4; w++)
          if ($urandom_range(0, 9) < 3)
            send_item(action_t'(op), word_idx_t'(w), word_t'({$urandom, $urandom}),
                      scalar_len_t'($urandom));
      if ($urandom_range(0, 9) == 0)
        send_item(ACT_UNUSED, word_idx_t'($urandom), word_t'({$urandom, $urandom}),
                  scalar_len_t'($urandom));
      if ($urandom_range(0, 9) < 8)
        start_run(($urandom_range(0, 9) < 8) ? scalar_len_t'($urandom_range(0, 4))
                                             : scalar_len_t'($urandom_range(5, 7)));
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
